// ===== sv/swwf_pkg.sv =====
`default_nettype none

package swwf_pkg;

   // Default sizing of the cell row and the score and step counters
   localparam int DEF_QUERY_CELLS = 64;
   localparam int DEF_SCORE_BITS  = 10;
   localparam int DEF_STEP_BITS   = 10;

   // Fixed field widths of the request and response channels
   localparam int CELL_IDX_BITS = 6;
   localparam int SYM_BITS      = 2;
   localparam int CFG_BITS      = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DIR_WORD_BITS = 64;

   // The max tree always spans the largest row; unused leaves read as zero
   localparam int TREE_LEAVES = 64;
   localparam int DIR_BITS    = 2 * TREE_LEAVES;

   // Database window entry: pad flag over the 2-bit symbol
   localparam int DB_BITS = SYM_BITS + 1;
   localparam logic [DB_BITS-1:0] DB_PAD_ENTRY = {1'b1, {SYM_BITS{1'b0}}};

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_STEP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DIAG = 2'd2,
      DIR_LEFT = 2'd3
   } dir_code_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MATCH_SCORE      = 2'd0,
      CSR_MISMATCH_PENALTY = 2'd1,
      CSR_VERTICAL_GAP     = 2'd2,
      CSR_HORIZONTAL_GAP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] match_score;
      logic [CFG_BITS-1:0] mismatch_penalty;
      logic [CFG_BITS-1:0] vertical_gap;
      logic [CFG_BITS-1:0] horizontal_gap;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      match_score:      4'd2,
      mismatch_penalty: 4'd1,
      vertical_gap:     4'd1,
      horizontal_gap:   4'd1
   };

   // Decoded command of one accepted request
   typedef struct packed {
      logic valid;
      logic step;
      logic clear;
      logic load;
   } req_ctl_type;

endpackage

`default_nettype wire

// ===== sv/swwf_req_if.sv =====
`default_nettype none

interface swwf_req_if import swwf_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   logic [CELL_IDX_BITS-1:0] query_index;
   logic [SYM_BITS-1:0]      query_symbol;
   logic [SYM_BITS-1:0]      db_symbol;
   logic                     db_pad;

   modport source (
      output valid, cmd, query_index, query_symbol, db_symbol, db_pad,
      input  ready
   );

   modport sink (
      input  valid, cmd, query_index, query_symbol, db_symbol, db_pad,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/swwf_rsp_if.sv =====
`default_nettype none

interface swwf_rsp_if import swwf_pkg::*; #(
   parameter int SCORE_BITS = DEF_SCORE_BITS,
   parameter int STEP_BITS  = DEF_STEP_BITS
) ();
   logic                     valid;
   logic                     ready;
   logic [DIR_WORD_BITS-1:0] dir_low;
   logic [DIR_WORD_BITS-1:0] dir_high;
   logic [SCORE_BITS-1:0]    step_max;
   logic [CELL_IDX_BITS-1:0] step_max_cell;
   logic [SCORE_BITS-1:0]    best_value;
   logic [STEP_BITS-1:0]     best_step;
   logic [CELL_IDX_BITS-1:0] best_cell;

   modport source (
      output valid, dir_low, dir_high, step_max, step_max_cell,
             best_value, best_step, best_cell,
      input  ready
   );

   modport sink (
      input  valid, dir_low, dir_high, step_max, step_max_cell,
             best_value, best_step, best_cell,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/swwf_csr_if.sv =====
`default_nettype none

interface swwf_csr_if import swwf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/swwf_cell.sv =====
`default_nettype none

module swwf_cell import swwf_pkg::*; #(
   parameter int SCORE_BITS = DEF_SCORE_BITS,
   parameter int CELL_ID    = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  req_ctl_type              ctl,
   input  cfg_type                  cfg,
   input  logic [CELL_IDX_BITS-1:0] query_index,
   input  logic [SYM_BITS-1:0]      query_symbol,
   input  logic [DB_BITS-1:0]       db_in,
   input  logic [SCORE_BITS-1:0]    nw_in,
   input  logic [SCORE_BITS-1:0]    w_in,
   output logic [DB_BITS-1:0]       db_out,
   output logic [SCORE_BITS-1:0]    h_last_out,
   output logic [SCORE_BITS-1:0]    h_prev_out,
   output dir_code_type             code_out
);

   localparam int SW = SCORE_BITS + 2;
   localparam logic [CELL_IDX_BITS-1:0] MY_INDEX = CELL_IDX_BITS'(CELL_ID);
   localparam logic signed [SW-1:0] SAT_MAX = {2'b00, {SCORE_BITS{1'b1}}};

   logic [SYM_BITS-1:0]   q_ff;
   logic [SCORE_BITS-1:0] h_last_ff;
   logic [SCORE_BITS-1:0] h_prev_ff;
   logic [DB_BITS-1:0]    db_ff;
   dir_code_type          code_ff;

   logic                  hit;
   logic signed [SW-1:0]  v_diag;
   logic signed [SW-1:0]  v_up;
   logic signed [SW-1:0]  v_left;
   logic signed [SW-1:0]  v_best;
   logic [SCORE_BITS-1:0] h_in;
   dir_code_type          code_in;

   // Score the three moves and pick by priority diagonal, up, left, zero
   always_comb begin
      hit = !db_in[DB_BITS-1] && (db_in[SYM_BITS-1:0] == q_ff);
      if (hit) begin
         v_diag = {2'b00, nw_in} + SW'(cfg.match_score);
      end else begin
         v_diag = {2'b00, nw_in} - SW'(cfg.mismatch_penalty);
      end
      v_up   = {2'b00, h_last_ff} - SW'(cfg.vertical_gap);
      v_left = {2'b00, w_in} - SW'(cfg.horizontal_gap);

      priority if (v_diag > 0 && v_diag >= v_up && v_diag >= v_left) begin
         v_best  = v_diag;
         code_in = DIR_DIAG;
      end else if (v_up > 0 && v_up >= v_left) begin
         v_best  = v_up;
         code_in = DIR_UP;
      end else if (v_left > 0) begin
         v_best  = v_left;
         code_in = DIR_LEFT;
      end else begin
         v_best  = '0;
         code_in = DIR_NONE;
      end

      // Saturate at the top of the score range
      if (v_best > SAT_MAX) begin
         h_in = SAT_MAX[SCORE_BITS-1:0];
      end else begin
         h_in = v_best[SCORE_BITS-1:0];
      end
   end

   // Hold cell state; advance it on a step, take the query symbol on a load to this cell, wipe it on a clear
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         q_ff      <= '0;
         h_last_ff <= '0;
         h_prev_ff <= '0;
         db_ff     <= DB_PAD_ENTRY;
      end else if (ctl.step) begin
         h_last_ff <= h_in;
         h_prev_ff <= h_last_ff;
         db_ff     <= db_in;
      end else if (ctl.load && query_index == MY_INDEX) begin
         q_ff <= query_symbol;
      end
   end

   // Direction code of the latest request; zero unless it was a step
   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         code_ff <= ctl.step ? code_in : DIR_NONE;
      end
   end

   assign db_out     = db_ff;
   assign h_last_out = h_last_ff;
   assign h_prev_out = h_prev_ff;
   assign code_out   = code_ff;

endmodule

`default_nettype wire

// ===== sv/swwf_max_tree.sv =====
`default_nettype none

module swwf_max_tree import swwf_pkg::*; #(
   parameter int SCORE_BITS = DEF_SCORE_BITS
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [SCORE_BITS-1:0]    leaf_val [TREE_LEAVES],
   output logic [SCORE_BITS-1:0]    max_val,
   output logic [CELL_IDX_BITS-1:0] max_cell
);

   localparam int FAN = 4;
   localparam int L1  = TREE_LEAVES / FAN;
   localparam int L2  = L1 / FAN;

   logic [SCORE_BITS-1:0]    a_val_in [L1];
   logic [CELL_IDX_BITS-1:0] a_idx_in [L1];
   logic [SCORE_BITS-1:0]    a_val_ff [L1];
   logic [CELL_IDX_BITS-1:0] a_idx_ff [L1];
   logic [SCORE_BITS-1:0]    b_val_in [L2];
   logic [CELL_IDX_BITS-1:0] b_idx_in [L2];
   logic [SCORE_BITS-1:0]    b_val_ff [L2];
   logic [CELL_IDX_BITS-1:0] b_idx_ff [L2];
   logic [SCORE_BITS-1:0]    c_val_in;
   logic [CELL_IDX_BITS-1:0] c_idx_in;
   logic [SCORE_BITS-1:0]    c_val_ff;
   logic [CELL_IDX_BITS-1:0] c_idx_ff;

   // Each node keeps the larger value; on a tie the higher cell wins
   always_comb begin
      for (int n = 0; n < L1; n++) begin
         a_val_in[n] = leaf_val[n*FAN];
         a_idx_in[n] = CELL_IDX_BITS'(n*FAN);
         for (int k = 1; k < FAN; k++) begin
            if (leaf_val[n*FAN+k] >= a_val_in[n]) begin
               a_val_in[n] = leaf_val[n*FAN+k];
               a_idx_in[n] = CELL_IDX_BITS'(n*FAN+k);
            end
         end
      end
      for (int n = 0; n < L2; n++) begin
         b_val_in[n] = a_val_ff[n*FAN];
         b_idx_in[n] = a_idx_ff[n*FAN];
         for (int k = 1; k < FAN; k++) begin
            if (a_val_ff[n*FAN+k] >= b_val_in[n]) begin
               b_val_in[n] = a_val_ff[n*FAN+k];
               b_idx_in[n] = a_idx_ff[n*FAN+k];
            end
         end
      end
      c_val_in = b_val_ff[0];
      c_idx_in = b_idx_ff[0];
      for (int k = 1; k < L2; k++) begin
         if (b_val_ff[k] >= c_val_in) begin
            c_val_in = b_val_ff[k];
            c_idx_in = b_idx_ff[k];
         end
      end
   end

   // Advance all three levels together
   always_ff @(posedge clock) begin
      if (enable) begin
         a_val_ff <= a_val_in;
         a_idx_ff <= a_idx_in;
         b_val_ff <= b_val_in;
         b_idx_ff <= b_idx_in;
         c_val_ff <= c_val_in;
         c_idx_ff <= c_idx_in;
      end
   end

   assign max_val  = c_val_ff;
   assign max_cell = c_idx_ff;

endmodule

`default_nettype wire

// ===== sv/smith_waterman_wavefront_unit.sv =====
`default_nettype none

// Linear-gap Smith-Waterman engine. A row of QUERY_CELLS cells holds the
// query; each step request pushes one database symbol into cell 0 and every
// cell computes its point of the current anti-diagonal in the same cycle.
// One request is taken per clock while the output does not stall; each
// result passes the cell row, a three-level registered max tree (four
// inputs per node) that finds the diagonal's maximum and its highest cell,
// and the output register. Clear and query-load requests travel the
// same pipeline and return all-zero direction codes and step maximum with
// the running best as it stands after them. The configuration port takes a
// write in any cycle; write it only while no request is in flight.
module smith_waterman_wavefront_unit import swwf_pkg::*; #(
   parameter int QUERY_CELLS = DEF_QUERY_CELLS,
   parameter int SCORE_BITS  = DEF_SCORE_BITS,
   parameter int STEP_BITS   = DEF_STEP_BITS
) (
   input  logic         clock,
   input  logic         reset,
   swwf_req_if.sink     req_bus,
   swwf_rsp_if.source   rsp_bus,
   swwf_csr_if.sink     csr_bus
);

   localparam int PIPE = 3;

   cfg_type                  cfg_ff;
   logic [STEP_BITS-1:0]     step_count_ff;
   req_ctl_type              req_ctl;
   req_ctl_type              ctl_s1_ff;
   logic [STEP_BITS-1:0]     step_s1_ff;
   req_ctl_type              ctl_pipe_ff  [PIPE];
   logic [STEP_BITS-1:0]     step_pipe_ff [PIPE];
   logic [DIR_BITS-1:0]      dir_pipe_ff  [PIPE];
   logic                     advance;
   logic                     accept;
   logic                     out_load;

   logic [SCORE_BITS-1:0]    h_last [QUERY_CELLS];
   logic [SCORE_BITS-1:0]    h_prev [QUERY_CELLS];
   logic [DB_BITS-1:0]       db_win [QUERY_CELLS];
   dir_code_type             code   [QUERY_CELLS];
   logic [SCORE_BITS-1:0]    leaf_val [TREE_LEAVES];
   logic [DIR_BITS-1:0]      dir_s1;
   logic [SCORE_BITS-1:0]    tree_max;
   logic [CELL_IDX_BITS-1:0] tree_cell;
   logic [CELL_IDX_BITS-1:0] max_cell;

   logic                     rsp_valid_ff;
   logic [DIR_BITS-1:0]      rsp_dir_ff;
   logic [SCORE_BITS-1:0]    rsp_max_ff;
   logic [CELL_IDX_BITS-1:0] rsp_cell_ff;
   logic [SCORE_BITS-1:0]    best_val_ff;
   logic [STEP_BITS-1:0]     best_step_ff;
   logic [CELL_IDX_BITS-1:0] best_cell_ff;

   // Stall the pipeline only when a finished result waits behind a full output
   assign out_load = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = !ctl_pipe_ff[PIPE-1].valid || out_load;
   assign accept   = req_bus.valid && advance;
   assign req_bus.ready = advance;
   assign csr_bus.ready = 1'b1;

   // Decode the accepted request
   always_comb begin
      req_ctl       = '0;
      req_ctl.valid = accept;
      unique case (cmd_type'(req_bus.cmd))
         CMD_CLEAR: req_ctl.clear = accept;
         CMD_LOAD:  req_ctl.load  = accept;
         CMD_STEP:  req_ctl.step  = accept;
         default:   ;
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_MATCH_SCORE:      cfg_ff.match_score      <= csr_bus.data;
            CSR_MISMATCH_PENALTY: cfg_ff.mismatch_penalty <= csr_bus.data;
            CSR_VERTICAL_GAP:     cfg_ff.vertical_gap     <= csr_bus.data;
            CSR_HORIZONTAL_GAP:   cfg_ff.horizontal_gap   <= csr_bus.data;
         endcase
      end
   end

   // Count steps, saturating at the top of the range
   always_ff @(posedge clock) begin
      if (reset || req_ctl.clear) begin
         step_count_ff <= '0;
      end else if (req_ctl.step && step_count_ff != {STEP_BITS{1'b1}}) begin
         step_count_ff <= step_count_ff + 1'b1;
      end
   end

   // Cell row: each cell hands its scores and database symbol to the next
   for (genvar i = 0; i < QUERY_CELLS; i++) begin : g_cell
      logic [DB_BITS-1:0]    db_in;
      logic [SCORE_BITS-1:0] nw_in;
      logic [SCORE_BITS-1:0] w_in;

      if (i == 0) begin : g_head
         assign db_in = {req_bus.db_pad, req_bus.db_symbol};
         assign nw_in = '0;
         assign w_in  = '0;
      end else begin : g_body
         assign db_in = db_win[i-1];
         assign nw_in = h_prev[i-1];
         assign w_in  = h_last[i-1];
      end

      swwf_cell #(
         .SCORE_BITS (SCORE_BITS),
         .CELL_ID    (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (req_ctl),
         .cfg          (cfg_ff),
         .query_index  (req_bus.query_index),
         .query_symbol (req_bus.query_symbol),
         .db_in        (db_in),
         .nw_in        (nw_in),
         .w_in         (w_in),
         .db_out       (db_win[i]),
         .h_last_out   (h_last[i]),
         .h_prev_out   (h_prev[i]),
         .code_out     (code[i])
      );
   end

   // Gather the row's fresh values and codes; unused positions read zero
   always_comb begin
      dir_s1 = '0;
      for (int i = 0; i < TREE_LEAVES; i++) begin
         leaf_val[i] = '0;
      end
      for (int i = 0; i < QUERY_CELLS; i++) begin
         leaf_val[i]     = ctl_s1_ff.step ? h_last[i] : '0;
         dir_s1[2*i +: 2] = code[i];
      end
   end

   swwf_max_tree #(
      .SCORE_BITS (SCORE_BITS)
   ) u_max_tree (
      .clock    (clock),
      .enable   (advance),
      .leaf_val (leaf_val),
      .max_val  (tree_max),
      .max_cell (tree_cell)
   );

   // Request tags alongside the row and the tree levels
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         for (int s = 0; s < PIPE; s++) begin
            ctl_pipe_ff[s] <= '0;
         end
      end else if (advance) begin
         ctl_s1_ff      <= req_ctl;
         ctl_pipe_ff[0] <= ctl_s1_ff;
         for (int s = 1; s < PIPE; s++) begin
            ctl_pipe_ff[s] <= ctl_pipe_ff[s-1];
         end
      end
   end

   // Step numbers and direction codes follow their tags
   always_ff @(posedge clock) begin
      if (advance) begin
         step_s1_ff      <= step_count_ff;
         step_pipe_ff[0] <= step_s1_ff;
         dir_pipe_ff[0]  <= dir_s1;
         for (int s = 1; s < PIPE; s++) begin
            step_pipe_ff[s] <= step_pipe_ff[s-1];
            dir_pipe_ff[s]  <= dir_pipe_ff[s-1];
         end
      end
   end

   // An all-zero diagonal reports cell zero
   assign max_cell = (tree_max == '0) ? '0 : tree_cell;

   // Running best: replace only on a strictly larger value; a clear resets it
   always_ff @(posedge clock) begin
      if (reset) begin
         best_val_ff  <= '0;
         best_step_ff <= '0;
         best_cell_ff <= '0;
      end else if (out_load && ctl_pipe_ff[PIPE-1].valid) begin
         if (ctl_pipe_ff[PIPE-1].clear) begin
            best_val_ff  <= '0;
            best_step_ff <= '0;
            best_cell_ff <= '0;
         end else if (ctl_pipe_ff[PIPE-1].step && tree_max > best_val_ff) begin
            best_val_ff  <= tree_max;
            best_step_ff <= step_pipe_ff[PIPE-1];
            best_cell_ff <= max_cell;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= ctl_pipe_ff[PIPE-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_dir_ff  <= dir_pipe_ff[PIPE-1];
         rsp_max_ff  <= tree_max;
         rsp_cell_ff <= max_cell;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.dir_low       = rsp_dir_ff[DIR_WORD_BITS-1:0];
   assign rsp_bus.dir_high      = rsp_dir_ff[DIR_BITS-1:DIR_WORD_BITS];
   assign rsp_bus.step_max      = rsp_max_ff;
   assign rsp_bus.step_max_cell = rsp_cell_ff;
   assign rsp_bus.best_value    = best_val_ff;
   assign rsp_bus.best_step     = best_step_ff;
   assign rsp_bus.best_cell     = best_cell_ff;

endmodule

`default_nettype wire
